// File: rtl/pglcd_pkg.sv
package pglcd_pkg;

  // Default geometry of one column-segment controller
  localparam int unsigned NumChipsDef = 3;
  localparam int unsigned ColumnsDef  = 64;
  localparam int unsigned PagesDef    = 8;

  // Chip-select field width; select bits beyond it never reach a chip
  localparam int unsigned SelW = 3;

  // Widest display RAM address: 3 page bits plus 6 column bits
  localparam int unsigned MaxAddrW = 9;

  // Bus access codes
  localparam logic [1:0] OpCmd    = 2'd0;
  localparam logic [1:0] OpWdata  = 2'd1;
  localparam logic [1:0] OpStatus = 2'd2;
  localparam logic [1:0] OpRdata  = 2'd3;

  // Command bytes and their decode masks
  localparam logic [7:0] CmdDispOff  = 8'h3E;
  localparam logic [7:0] CmdDispOn   = 8'h3F;
  localparam logic [7:0] CmdColumn   = 8'h40;
  localparam logic [7:0] CmdPage     = 8'hB8;
  localparam logic [7:0] CmdStart    = 8'hC0;
  localparam logic [7:0] MaskDisp    = 8'hFE;
  localparam logic [7:0] MaskColumn  = 8'hC0;
  localparam logic [7:0] MaskPage    = 8'hF8;
  localparam logic [7:0] MaskStart   = 8'hC0;

  // Status byte: busy (bit 7) never set, bit 5 while the display is off
  localparam logic [7:0] StatusOff   = 8'h20;
  localparam logic [7:0] StatusOn    = 8'h00;

  typedef struct packed {
    logic [1:0]      op;
    logic [SelW-1:0] chip_select;
    logic [7:0]      data_in;
  } pglcd_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       is_read;
  } pglcd_out_t;

  // Access class after decode in the front end
  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_DISP,
    KIND_COL,
    KIND_PAGE,
    KIND_START,
    KIND_WDATA,
    KIND_STATUS,
    KIND_RDATA
  } pglcd_kind_e;

  // Decoded access held in the queue
  typedef struct packed {
    pglcd_kind_e     kind;
    logic [SelW-1:0] sel;
    logic [7:0]      arg;
    logic            is_read;
  } pglcd_item_t;

  // Power-on clearing sweep of the display RAMs
  typedef struct packed {
    logic                en;
    logic [MaxAddrW-1:0] addr;
  } pglcd_clr_t;

  // Reduce a 6-bit value below a small limit by repeated subtraction.
  // Values here stay under 64 and limits are at least 8 (columns) or the
  // value is under 8 (pages), so eight steps always suffice.
  function automatic logic [5:0] mod_small(input logic [5:0] v, input int unsigned m);
    logic [5:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (32'(r) >= m) begin
        r = r - 6'(m);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/pglcd_front.sv
module pglcd_front #(
  parameter int unsigned COLUMNS = pglcd_pkg::ColumnsDef,
  parameter int unsigned PAGES   = pglcd_pkg::PagesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clearing_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pglcd_pkg::pglcd_in_t  in_data_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output pglcd_pkg::pglcd_item_t q_item_o
);
  import pglcd_pkg::*;

  pglcd_item_t item_d;
  pglcd_item_t fifo_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  // Classify the access and pre-reduce address arguments
  always_comb begin
    item_d.kind    = KIND_NOP;
    item_d.sel     = in_data_i.chip_select;
    item_d.arg     = in_data_i.data_in;
    item_d.is_read = 1'b0;
    case (in_data_i.op)
      OpCmd: begin
        if ((in_data_i.data_in & MaskDisp) == CmdDispOff) begin
          item_d.kind = KIND_DISP;
          item_d.arg  = {7'd0, in_data_i.data_in == CmdDispOn};
        end else if ((in_data_i.data_in & MaskColumn) == CmdColumn) begin
          item_d.kind = KIND_COL;
          item_d.arg  = {2'd0, mod_small(in_data_i.data_in[5:0], COLUMNS)};
        end else if ((in_data_i.data_in & MaskPage) == CmdPage) begin
          item_d.kind = KIND_PAGE;
          item_d.arg  = {2'd0, mod_small({3'd0, in_data_i.data_in[2:0]}, PAGES)};
        end else if ((in_data_i.data_in & MaskStart) == CmdStart) begin
          item_d.kind = KIND_START;
        end
      end
      OpWdata:  item_d.kind = KIND_WDATA;
      OpStatus: begin
        item_d.kind    = KIND_STATUS;
        item_d.is_read = 1'b1;
      end
      OpRdata: begin
        item_d.kind    = KIND_RDATA;
        item_d.is_read = 1'b1;
      end
      default:  item_d.kind = KIND_NOP;
    endcase
  end

  // Two-entry queue toward the back end
  assign in_ready_o = (count_q != 2'd2) && !clearing_i;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_d;
    end
  end

  // Queue occupancy never overflows
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

  // A lone transfer in grows the queue by one
  a_count_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count did not follow push");

endmodule

// File: rtl/pglcd_lane.sv
module pglcd_lane #(
  parameter int unsigned COLUMNS = pglcd_pkg::ColumnsDef,
  parameter int unsigned PAGES   = pglcd_pkg::PagesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic                   sel_i,
  input  pglcd_pkg::pglcd_item_t item_i,
  input  pglcd_pkg::pglcd_clr_t  clr_i,
  output logic [7:0]             rd_val_o
);
  import pglcd_pkg::*;

  localparam int unsigned CW        = $clog2(COLUMNS);
  localparam int unsigned PW        = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned AW        = PW + CW;
  localparam int unsigned MemDepth  = 1 << AW;
  localparam logic [CW-1:0] ColLast = CW'(COLUMNS - 1);

  logic [7:0]    mem [MemDepth];
  logic [CW-1:0] col_q, col_inc;
  logic [PW-1:0] page_q;
  logic          en_q;
  logic [7:0]    latch_q, latch_eff;
  logic          pend_q;
  logic [7:0]    rdata_q;
  logic          hit, do_wr, do_rd, mem_we;
  logic [AW-1:0] addr, mem_waddr;
  logic [7:0]    mem_wdata;

  assign hit   = fire_i && sel_i;
  assign do_wr = hit && (item_i.kind == KIND_WDATA);
  assign do_rd = hit && (item_i.kind == KIND_RDATA);
  assign addr  = {page_q, col_q};

  // Column auto-increment with wrap
  assign col_inc = (col_q == ColLast) ? '0 : col_q + CW'(1);

  // Output latch, with the RAM word of the previous data read forwarded
  assign latch_eff = pend_q ? rdata_q : latch_q;

  assign rd_val_o = (item_i.kind == KIND_STATUS) ? (en_q ? StatusOn : StatusOff) : latch_eff;

  // RAM port: clearing sweep or display data write
  assign mem_we    = clr_i.en || do_wr;
  assign mem_waddr = clr_i.en ? clr_i.addr[AW-1:0] : addr;
  assign mem_wdata = clr_i.en ? 8'd0 : item_i.arg;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (do_rd) begin
      rdata_q <= mem[addr];
    end
  end

  // Address, display flag and latch registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      page_q  <= '0;
      en_q    <= 1'b0;
      latch_q <= 8'd0;
      pend_q  <= 1'b0;
    end else begin
      if (pend_q) begin
        latch_q <= rdata_q;
      end
      pend_q <= do_rd;
      if (hit) begin
        case (item_i.kind)
          KIND_DISP:  en_q   <= item_i.arg[0];
          KIND_COL:   col_q  <= item_i.arg[CW-1:0];
          KIND_PAGE:  page_q <= item_i.arg[PW-1:0];
          KIND_WDATA: col_q  <= col_inc;
          KIND_RDATA: col_q  <= col_inc;
          default:    ;
        endcase
      end
    end
  end

  // A pending latch reload always comes from a data read in the previous cycle
  a_pend_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(do_rd)) else $error("latch reload without data read");

  // No access reaches the lane while the RAM is being cleared
  a_clr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i.en |-> !fire_i) else $error("access during clearing sweep");

endmodule

// File: rtl/pglcd_back.sv
module pglcd_back #(
  parameter int unsigned NUM_CHIPS = pglcd_pkg::NumChipsDef,
  parameter int unsigned COLUMNS   = pglcd_pkg::ColumnsDef,
  parameter int unsigned PAGES     = pglcd_pkg::PagesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  pglcd_pkg::pglcd_item_t q_item_i,
  input  pglcd_pkg::pglcd_clr_t  clr_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output pglcd_pkg::pglcd_out_t  out_data_o
);
  import pglcd_pkg::*;

  logic              fire;
  logic [NUM_CHIPS-1:0] lane_sel;
  logic [7:0]        lane_val [NUM_CHIPS];
  logic [7:0]        rd_sel;
  pglcd_out_t        res_d, out_q;
  logic              out_valid_q;

  // Output register frees up when empty or when its transfer completes
  assign q_ready_o = !out_valid_q || out_ready_i;
  assign fire      = q_valid_i && q_ready_o;

  // One lane per controller; select bits past the bus field never hit
  for (genvar c = 0; c < NUM_CHIPS; c++) begin : g_lane
    if (c < SelW) begin : g_sel
      assign lane_sel[c] = q_item_i.sel[c];
    end else begin : g_nosel
      assign lane_sel[c] = 1'b0;
    end

    pglcd_lane #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .fire_i   (fire),
      .sel_i    (lane_sel[c]),
      .item_i   (q_item_i),
      .clr_i    (clr_i),
      .rd_val_o (lane_val[c])
    );
  end

  // Lowest selected controller answers a read
  always_comb begin
    rd_sel = 8'd0;
    for (int c = NUM_CHIPS - 1; c >= 0; c--) begin
      if (lane_sel[c]) begin
        rd_sel = lane_val[c];
      end
    end
    res_d.is_read   = q_item_i.is_read;
    res_d.read_data = q_item_i.is_read ? rd_sel : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Every executed access leaves a result in the output register
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q) else $error("executed access lost its result");

endmodule

// File: rtl/paged_lcd_controller_ram.sv
// Bank of paged graphic LCD column controllers seen as one bus device: each
// input transfer is one bus access (command write, data write, status read or
// data read) and yields exactly one result transfer. After reset the block
// first sweeps every controller's display RAM to zero, one word per cycle in
// all controllers at once; no access is taken during the sweep. After that
// one access per cycle is sustained while the result side accepts every
// result. Each taken access is decoded and enters the decode queue; the
// queue head then executes against the controller registers and RAM and
// loads the output register. The single RAM port per controller and the
// forwarding of the freshly read word into the output latch let data reads
// follow each other every cycle unless the result side holds them off; the
// first data read after an address change returns the old latch (dummy read).
module paged_lcd_controller_ram #(
  parameter int unsigned NUM_CHIPS = pglcd_pkg::NumChipsDef,
  parameter int unsigned COLUMNS   = pglcd_pkg::ColumnsDef,
  parameter int unsigned PAGES     = pglcd_pkg::PagesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pglcd_pkg::pglcd_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pglcd_pkg::pglcd_out_t out_data_o
);
  import pglcd_pkg::*;

  localparam int unsigned CW       = $clog2(COLUMNS);
  localparam int unsigned PW       = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned AW       = PW + CW;
  localparam logic [AW-1:0] AddrLast = '1;

  logic          clearing_q;
  logic [AW-1:0] clr_cnt_q;
  pglcd_clr_t    clr;
  logic          q_valid, q_ready;
  pglcd_item_t   q_item;

  // Power-on clearing sweep of the display RAMs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AddrLast) begin
        clearing_q <= 1'b0;
      end
    end
  end

  assign clr.en   = clearing_q;
  assign clr.addr = MaxAddrW'(clr_cnt_q);

  pglcd_front #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clearing_i (clearing_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  pglcd_back #(
    .NUM_CHIPS (NUM_CHIPS),
    .COLUMNS   (COLUMNS),
    .PAGES     (PAGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .clr_i       (clr),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // No access is taken while the RAMs are being cleared
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !in_ready_o) else $error("input open during clearing sweep");

endmodule

// File: bench/lcd_bus_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the LCD controller bank, keeps its own copy of
// every controller's registers and display RAM, and compares each result
// transfer with the reply predicted for the oldest outstanding access.
module lcd_bus_checker
  import pglcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  pglcd_in_t  in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  pglcd_out_t out_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  localparam int unsigned Chips = NumChipsDef;
  localparam int unsigned Cols  = ColumnsDef;
  localparam int unsigned Pages = PagesDef;
  localparam int          MaxReports = 10;

  // Shadow state of each controller
  logic [7:0] disp_ram [Chips][Pages][Cols];
  logic [5:0] col_addr [Chips];
  logic [2:0] page_addr [Chips];
  logic [5:0] start_line [Chips];
  logic       disp_on [Chips];
  logic [7:0] out_latch [Chips];

  // Replies owed by the block, oldest first
  pglcd_out_t owed_replies [$];
  pglcd_out_t want;
  int         n_reported;

  // Apply one bus access to the shadow controllers and return its reply
  function automatic pglcd_out_t apply_access(input pglcd_in_t acc);
    pglcd_out_t reply;
    logic       found;
    logic [7:0] val;
    logic [7:0] cmd;
    int         pg;
    int         cl;
    reply = '0;
    found = 1'b0;
    cmd   = acc.data_in;
    for (int c = 0; c < Chips && c < SelW; c++) begin
      if (acc.chip_select[c]) begin
        pg  = page_addr[c] % Pages;
        cl  = col_addr[c] % Cols;
        val = '0;
        case (acc.op)
          OpCmd: begin
            if ((cmd & MaskDisp) == CmdDispOff) begin
              disp_on[c] = cmd[0];
            end else if ((cmd & MaskColumn) == CmdColumn) begin
              col_addr[c] = 6'(cmd[5:0] % Cols);
            end else if ((cmd & MaskPage) == CmdPage) begin
              page_addr[c] = 3'(cmd[2:0] % Pages);
            end else if ((cmd & MaskStart) == CmdStart) begin
              start_line[c] = cmd[5:0];
            end
          end
          OpWdata: begin
            disp_ram[c][pg][cl] = cmd;
            col_addr[c] = (cl == Cols - 1) ? 6'd0 : 6'(cl + 1);
          end
          OpStatus: begin
            val = disp_on[c] ? StatusOn : StatusOff;
          end
          default: begin
            // data read hands out the latch, then refills it from RAM
            val = out_latch[c];
            out_latch[c] = disp_ram[c][pg][cl];
            col_addr[c] = (cl == Cols - 1) ? 6'd0 : 6'(cl + 1);
          end
        endcase
        // lowest selected chip drives the read value
        if (!found) begin
          found = 1'b1;
          reply.read_data = val;
        end
      end
    end
    reply.is_read = (acc.op == OpStatus) || (acc.op == OpRdata);
    if (!reply.is_read) begin
      reply.read_data = '0;
    end
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < Chips; c++) begin
        for (int p = 0; p < Pages; p++) begin
          for (int k = 0; k < Cols; k++) begin
            disp_ram[c][p][k] = '0;
          end
        end
        col_addr[c]   = '0;
        page_addr[c]  = '0;
        start_line[c] = '0;
        disp_on[c]    = 1'b0;
        out_latch[c]  = '0;
      end
      owed_replies.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      n_reported   = 0;
    end else begin
      // result side first: it always belongs to an earlier access
      if (out_valid_i && out_ready_i) begin
        if (owed_replies.size() == 0) begin
          fail_count_o++;
          if (n_reported < MaxReports) begin
            n_reported++;
            $display("%0t: result with nothing owed: read_data %02h is_read %0b",
                     $realtime, out_data_i.read_data, out_data_i.is_read);
          end
        end else begin
          want = owed_replies.pop_front();
          checked_o++;
          if (want.read_data !== out_data_i.read_data ||
              want.is_read !== out_data_i.is_read) begin
            fail_count_o++;
            if (n_reported < MaxReports) begin
              n_reported++;
              $display("%0t: mismatch: read_data exp %02h got %02h, is_read exp %0b got %0b",
                       $realtime, want.read_data, out_data_i.read_data,
                       want.is_read, out_data_i.is_read);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        owed_replies.push_back(apply_access(in_data_i));
      end
      pending_o = owed_replies.size();
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

// Drives bus accesses into the LCD controller bank and gives the verdict;
// all checking lives in lcd_bus_checker.
module tb;
  import pglcd_pkg::*;

  localparam int IdleLimit   = 4000;
  localparam int RandomItems = 1450;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  pglcd_in_t  in_data;
  logic       out_valid;
  logic       out_ready;
  pglcd_out_t out_data;

  int   fail_count;
  int   pending;
  int   checked;
  logic calm;
  int   n_items;
  int   n_bursts;
  int   sent_ops [4];
  int   quiet_cycles;

  paged_lcd_controller_ram u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  lcd_bus_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= calm || ($urandom_range(0, 99) >= 18);
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles", IdleLimit);
      $display("paged_lcd_controller_ram test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One access; called at a falling edge, returns at the falling edge after
  // its transfer
  task automatic send_access(input logic [1:0] acc_op, input logic [SelW-1:0] acc_cs,
                             input logic [7:0] acc_data);
    if (!calm && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < 18) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: acc_op, chip_select: acc_cs, data_in: acc_data};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_ops[acc_op]++;
    n_items++;
  endtask

  // Hold the sender off until every owed result has come back
  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Write a run of bytes at one address, then read them back (dummy first)
  task automatic write_then_read();
    logic [SelW-1:0] wr_cs;
    logic [SelW-1:0] rd_cs;
    logic [2:0]      pg;
    logic [5:0]      cl;
    int              len;
    wr_cs = SelW'($urandom_range(1, 7));
    pg    = 3'($urandom_range(0, 7));
    cl    = 6'($urandom_range(0, 63));
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
    send_access(OpCmd, wr_cs, CmdPage | 8'(pg));
    send_access(OpCmd, wr_cs, CmdColumn | 8'(cl));
    repeat (len) send_access(OpWdata, wr_cs, 8'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      send_access(OpCmd, SelW'($urandom_range(0, 7)), CmdDispOff | 8'($urandom_range(0, 1)));
      send_access(OpStatus, SelW'($urandom_range(0, 7)), 8'($urandom));
    end
    rd_cs = ($urandom_range(0, 2) != 0) ? wr_cs : SelW'($urandom_range(0, 7));
    send_access(OpCmd, rd_cs, CmdPage | 8'(pg));
    send_access(OpCmd, rd_cs, CmdColumn | 8'(cl));
    repeat (len + 1) send_access(OpRdata, rd_cs, 8'($urandom));
    n_bursts++;
  endtask

  // Stimulus and verdict
  initial begin
    logic [1:0] op;
    logic [7:0] data;
    logic       paused_mid;
    in_valid   = 1'b0;
    in_data    = '0;
    calm       = 1'b0;
    n_items    = 0;
    n_bursts   = 0;
    paused_mid = 1'b0;
    for (int i = 0; i < 4; i++) sent_ops[i] = 0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: status with display off and on, no chip selected,
    // extreme addresses with column wrap, dummy read, ignored commands
    send_access(OpStatus, 3'b111, 8'h00);
    send_access(OpStatus, 3'b000, 8'hFF);
    send_access(OpRdata,  3'b000, 8'hFF);
    send_access(OpCmd,    3'b111, CmdDispOn);
    send_access(OpStatus, 3'b100, 8'h00);
    send_access(OpCmd,    3'b001, CmdDispOff);
    send_access(OpStatus, 3'b011, 8'h00);
    send_access(OpStatus, 3'b110, 8'h00);
    send_access(OpCmd,    3'b111, 8'hBF);
    send_access(OpCmd,    3'b111, 8'h7F);
    send_access(OpWdata,  3'b111, 8'hFF);
    send_access(OpWdata,  3'b101, 8'h00);
    send_access(OpWdata,  3'b000, 8'hA5);
    send_access(OpCmd,    3'b111, 8'h7F);
    send_access(OpRdata,  3'b010, 8'h00);
    send_access(OpRdata,  3'b010, 8'h00);
    send_access(OpRdata,  3'b111, 8'hFF);
    send_access(OpCmd,    3'b111, 8'hFF);
    send_access(OpCmd,    3'b111, CmdStart);
    send_access(OpCmd,    3'b111, 8'h00);
    send_access(OpCmd,    3'b111, 8'h80);
    send_access(OpCmd,    3'b111, CmdPage);
    send_access(OpCmd,    3'b111, CmdColumn);
    send_access(OpWdata,  3'b111, 8'h5A);
    send_access(OpCmd,    3'b001, CmdDispOn);
    send_access(OpStatus, 3'b111, 8'h00);
    drain_replies();

    // Random: mostly write/read-back bursts, the rest loose accesses
    while (n_items < 26 + RandomItems) begin
      calm = (n_items >= 500) && (n_items < 800);
      if (!paused_mid && n_items >= 1000) begin
        paused_mid = 1'b1;
        drain_replies();
      end
      if ($urandom_range(0, 99) < 70) begin
        write_then_read();
      end else begin
        op   = 2'($urandom_range(0, 3));
        data = 8'($urandom);
        if (op == OpCmd && $urandom_range(0, 3) == 0) begin
          data = CmdDispOff | 8'($urandom_range(0, 1));
        end
        send_access(op, SelW'($urandom_range(0, 7)), data);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Let everything owed come back, then wait on for any stray results
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d accesses: %0d commands, %0d data writes, %0d status reads, %0d data reads",
             n_items, sent_ops[OpCmd], sent_ops[OpWdata], sent_ops[OpStatus], sent_ops[OpRdata]);
    $display("%0d write/read-back bursts, %0d results compared", n_bursts, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("paged_lcd_controller_ram test passed");
    end else begin
      $display("paged_lcd_controller_ram test failed");
    end
    $finish;
  end

endmodule
